// File: rtl/gpe_pkg.sv
`timescale 1ns / 1ps
// Shared constants, tables and control types of the gate position estimator.
package gpe_pkg;

    // Field and state widths
    localparam int TABLE_POINTS  = 8;
    localparam int POSITION_BITS = 16;
    localparam int CUR_W         = 10;
    localparam int SPD_W         = 10;
    localparam int STEP_W        = 5;
    localparam int DIST_W        = 16;
    localparam int LIMIT_W       = 16;
    localparam int OUT_POS_W     = 16;
    localparam int POS_EXT_W     = (POSITION_BITS > OUT_POS_W) ? POSITION_BITS : OUT_POS_W;
    localparam int SEG_W         = $clog2(TABLE_POINTS);

    // Reciprocal divider: quotient = (num * floor(2^S / d)) >> S, then one fix-up
    localparam int NUM_W         = 16;
    localparam int RECIP_SHIFT   = 16;
    localparam int RECIP_W       = RECIP_SHIFT + 1;
    localparam int DX_W          = CUR_W;
    localparam int PROD_W        = NUM_W + RECIP_W;
    localparam int SPEED_DIVISOR = 20;

    // Operation codes of an input word
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_STOP   = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_POS_UPPER  = 2'd0;
    localparam logic [1:0] REG_POS_LOWER  = 2'd1;
    localparam logic [1:0] REG_FAST_OPEN  = 2'd2;
    localparam logic [1:0] REG_FAST_CLOSE = 2'd3;

    // Configuration reset values
    localparam logic signed [LIMIT_W-1:0] RST_POS_UPPER  = 16'sd10000;
    localparam logic signed [LIMIT_W-1:0] RST_POS_LOWER  = 16'sd0;
    localparam logic signed [LIMIT_W-1:0] RST_FAST_OPEN  = 16'sd2000;
    localparam logic signed [LIMIT_W-1:0] RST_FAST_CLOSE = 16'sd8000;

    // Current-to-speed table
    typedef logic [CUR_W-1:0]   cur_arr_t   [TABLE_POINTS];
    typedef logic [SPD_W-1:0]   spd_arr_t   [TABLE_POINTS];
    typedef logic [DX_W-1:0]    dx_arr_t    [TABLE_POINTS];
    typedef logic [RECIP_W-1:0] recip_arr_t [TABLE_POINTS];

    localparam cur_arr_t CUR_PTS = '{8, 11, 15, 20, 25, 30, 40, 50};
    localparam spd_arr_t SPD_PTS = '{587, 575, 561, 544, 529, 515, 490, 380};

    // Segment width; a flat or empty segment and the last point use one
    function automatic dx_arr_t mk_dx();
        dx_arr_t r;
        for (int i = 0; i < TABLE_POINTS - 1; i++)
        begin
            if (CUR_PTS[i+1] > CUR_PTS[i])
                r[i] = DX_W'(CUR_PTS[i+1] - CUR_PTS[i]);
            else
                r[i] = DX_W'(1);
        end
        r[TABLE_POINTS-1] = DX_W'(1);
        return r;
    endfunction

    // Speed drop over a segment; a rising or empty segment keeps its left speed
    function automatic spd_arr_t mk_dy();
        spd_arr_t r;
        for (int i = 0; i < TABLE_POINTS - 1; i++)
        begin
            if (CUR_PTS[i+1] > CUR_PTS[i] && SPD_PTS[i+1] <= SPD_PTS[i])
                r[i] = SPD_W'(SPD_PTS[i] - SPD_PTS[i+1]);
            else
                r[i] = '0;
        end
        r[TABLE_POINTS-1] = '0;
        return r;
    endfunction

    localparam dx_arr_t SEG_DX = mk_dx();
    localparam spd_arr_t SEG_DY = mk_dy();

    function automatic recip_arr_t mk_recip();
        recip_arr_t r;
        for (int i = 0; i < TABLE_POINTS; i++)
            r[i] = RECIP_W'((64'd1 << RECIP_SHIFT) / SEG_DX[i]);
        return r;
    endfunction

    localparam recip_arr_t SEG_RECIP = mk_recip();
    localparam logic [RECIP_W-1:0] RECIP_SPEED =
        RECIP_W'((64'd1 << RECIP_SHIFT) / SPEED_DIVISOR);

    // Microcode
    localparam int PC_W = 4;

    typedef enum logic [3:0] {
        U_NOP,
        U_SEG,
        U_MUL,
        U_RECIP,
        U_REM,
        U_QUOT,
        U_STEP,
        U_STOP,
        U_START
    } uop_t;

    typedef enum logic {
        D_SEG,
        D_SPEED
    } dsel_t;

    typedef enum logic [2:0] {
        J_NONE,
        J_ALWAYS,
        J_UPD,
        J_STOP,
        J_START
    } jcond_t;

    typedef struct packed {
        uop_t             uop;
        dsel_t            dsel;
        jcond_t           jc;
        logic [PC_W-1:0]  target;
        logic             done;
    } ctrl_t;

    typedef struct packed {
        logic upd;
        logic stop;
        logic start;
    } cond_t;

endpackage

// File: rtl/gpe_item_if.sv
`timescale 1ns / 1ps
// Input channel: one update, stop or start word per handshake.
interface gpe_item_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic                      gate_select;
    logic                      motor_running;
    logic                      direction_open;
    logic [gpe_pkg::CUR_W-1:0] motor_current;

    modport source (
        output valid, opcode, gate_select, motor_running, direction_open, motor_current,
        input  ready
    );

    modport sink (
        input  valid, opcode, gate_select, motor_running, direction_open, motor_current,
        output ready
    );
endinterface

// File: rtl/gpe_result_if.sv
`timescale 1ns / 1ps
// Result channel: selected gate state after each input word.
interface gpe_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [gpe_pkg::OUT_POS_W-1:0] position;
    logic [gpe_pkg::DIST_W-1:0]          travelled_distance;
    logic [gpe_pkg::STEP_W-1:0]          step_distance;
    logic                                fast_ride_allowed;

    modport source (
        output valid, position, travelled_distance, step_distance, fast_ride_allowed,
        input  ready
    );

    modport sink (
        input  valid, position, travelled_distance, step_distance, fast_ride_allowed,
        output ready
    );
endinterface

// File: rtl/gpe_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store and conditional jumps.
module gpe_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  gpe_pkg::cond_t  cond,
    input  logic            stall,
    output gpe_pkg::ctrl_t  ctrl,
    output logic            busy
);

    // Program addresses
    localparam logic [gpe_pkg::PC_W-1:0] PC_DISPATCH  = 4'd0;
    localparam logic [gpe_pkg::PC_W-1:0] PC_CHK_STOP  = 4'd1;
    localparam logic [gpe_pkg::PC_W-1:0] PC_CHK_START = 4'd2;
    localparam logic [gpe_pkg::PC_W-1:0] PC_FINISH    = 4'd3;
    localparam logic [gpe_pkg::PC_W-1:0] PC_SEG       = 4'd4;
    localparam logic [gpe_pkg::PC_W-1:0] PC_MUL       = 4'd5;
    localparam logic [gpe_pkg::PC_W-1:0] PC_RCP_SEG   = 4'd6;
    localparam logic [gpe_pkg::PC_W-1:0] PC_REM_SEG   = 4'd7;
    localparam logic [gpe_pkg::PC_W-1:0] PC_QUOT      = 4'd8;
    localparam logic [gpe_pkg::PC_W-1:0] PC_RCP_SPD   = 4'd9;
    localparam logic [gpe_pkg::PC_W-1:0] PC_REM_SPD   = 4'd10;
    localparam logic [gpe_pkg::PC_W-1:0] PC_STEP      = 4'd11;
    localparam logic [gpe_pkg::PC_W-1:0] PC_STOP      = 4'd12;
    localparam logic [gpe_pkg::PC_W-1:0] PC_START     = 4'd13;

    logic                         busy_reg;
    logic                         busy_next;
    logic [gpe_pkg::PC_W-1:0]     pc_reg;
    logic [gpe_pkg::PC_W-1:0]     pc_next;
    logic                         taken;

    function automatic gpe_pkg::ctrl_t cw(
        input gpe_pkg::uop_t             uop,
        input gpe_pkg::dsel_t            dsel,
        input gpe_pkg::jcond_t           jc,
        input logic [gpe_pkg::PC_W-1:0]  target,
        input logic                      done
    );
        gpe_pkg::ctrl_t c;
        c.uop    = uop;
        c.dsel   = dsel;
        c.jc     = jc;
        c.target = target;
        c.done   = done;
        return c;
    endfunction

    // Control store
    function automatic gpe_pkg::ctrl_t rom(input logic [gpe_pkg::PC_W-1:0] pc);
        gpe_pkg::ctrl_t c;
        unique case (pc)
            PC_DISPATCH:  c = cw(gpe_pkg::U_NOP,   gpe_pkg::D_SEG,   gpe_pkg::J_UPD,    PC_SEG,    1'b0);
            PC_CHK_STOP:  c = cw(gpe_pkg::U_NOP,   gpe_pkg::D_SEG,   gpe_pkg::J_STOP,   PC_STOP,   1'b0);
            PC_CHK_START: c = cw(gpe_pkg::U_NOP,   gpe_pkg::D_SEG,   gpe_pkg::J_START,  PC_START,  1'b0);
            PC_FINISH:    c = cw(gpe_pkg::U_NOP,   gpe_pkg::D_SEG,   gpe_pkg::J_NONE,   PC_FINISH, 1'b1);
            PC_SEG:       c = cw(gpe_pkg::U_SEG,   gpe_pkg::D_SEG,   gpe_pkg::J_NONE,   PC_FINISH, 1'b0);
            PC_MUL:       c = cw(gpe_pkg::U_MUL,   gpe_pkg::D_SEG,   gpe_pkg::J_NONE,   PC_FINISH, 1'b0);
            PC_RCP_SEG:   c = cw(gpe_pkg::U_RECIP, gpe_pkg::D_SEG,   gpe_pkg::J_NONE,   PC_FINISH, 1'b0);
            PC_REM_SEG:   c = cw(gpe_pkg::U_REM,   gpe_pkg::D_SEG,   gpe_pkg::J_NONE,   PC_FINISH, 1'b0);
            PC_QUOT:      c = cw(gpe_pkg::U_QUOT,  gpe_pkg::D_SEG,   gpe_pkg::J_NONE,   PC_FINISH, 1'b0);
            PC_RCP_SPD:   c = cw(gpe_pkg::U_RECIP, gpe_pkg::D_SPEED, gpe_pkg::J_NONE,   PC_FINISH, 1'b0);
            PC_REM_SPD:   c = cw(gpe_pkg::U_REM,   gpe_pkg::D_SPEED, gpe_pkg::J_NONE,   PC_FINISH, 1'b0);
            PC_STEP:      c = cw(gpe_pkg::U_STEP,  gpe_pkg::D_SPEED, gpe_pkg::J_ALWAYS, PC_FINISH, 1'b0);
            PC_STOP:      c = cw(gpe_pkg::U_STOP,  gpe_pkg::D_SEG,   gpe_pkg::J_ALWAYS, PC_FINISH, 1'b0);
            PC_START:     c = cw(gpe_pkg::U_START, gpe_pkg::D_SEG,   gpe_pkg::J_ALWAYS, PC_FINISH, 1'b0);
            default:      c = cw(gpe_pkg::U_NOP,   gpe_pkg::D_SEG,   gpe_pkg::J_NONE,   PC_FINISH, 1'b1);
        endcase
        return c;
    endfunction

    assign ctrl = rom(pc_reg);
    assign busy = busy_reg;

    // Evaluate the jump condition of the current step
    always_comb
    begin
        unique case (ctrl.jc)
            gpe_pkg::J_NONE:   taken = 1'b0;
            gpe_pkg::J_ALWAYS: taken = 1'b1;
            gpe_pkg::J_UPD:    taken = cond.upd;
            gpe_pkg::J_STOP:   taken = cond.stop;
            gpe_pkg::J_START:  taken = cond.start;
            default:           taken = 1'b0;
        endcase
    end

    // Advance, jump, or hold on the last step while the result register is full and not taken
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        priority if (start)
        begin
            busy_next = 1'b1;
            pc_next   = PC_DISPATCH;
        end
        else if (busy_reg)
        begin
            if (ctrl.done)
            begin
                if (!stall)
                    busy_next = 1'b0;
            end
            else if (taken)
                pc_next = ctrl.target;
            else
                pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= PC_DISPATCH;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

endmodule

// File: rtl/gate_position_estimator_unit.sv
`timescale 1ns / 1ps
// Gate position estimator: two gates tracked by dead reckoning from motor current.
//
// item_in carries one word per handshake: a period update, a stop clamp or a
// start check for one of two gates. result_out returns exactly one word per
// input word: the selected gate's position, travelled distance, the step added
// by this word and its fast-ride flag. cfg_wen/cfg_index/cfg_data write the
// four limit registers; write them only while the unit is idle.
// Items are handled one at a time by a microcoded sequencer. A running update
// takes segment lookup, multiply and two reciprocal divisions of two steps
// each; a stop clamp or a start check takes the dispatch checks, its own step
// and the finishing step; anything else only the dispatch checks and the
// finishing step. item_in.ready rises as the result loads, and is high whenever
// no item is in work, so the next word is accepted while a result still waits
// in the output register. If the receiver stalls, the next item runs to its
// last step and holds there until the output register frees.
// Reset clears both gates' position, distance and flag, loads the limit
// registers with their defaults and empties the output register.
module gate_position_estimator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    gpe_item_if.sink                      item_in,
    gpe_result_if.source                  result_out,
    input  logic                          cfg_wen,
    input  logic [1:0]                    cfg_index,
    input  logic [gpe_pkg::LIMIT_W-1:0]   cfg_data
);

    localparam int PB = gpe_pkg::POSITION_BITS;
    localparam int EW = gpe_pkg::POS_EXT_W;

    // Sequencer link
    gpe_pkg::ctrl_t ctrl;
    gpe_pkg::cond_t cond;
    logic           busy;
    logic           accept;
    logic           stall;
    logic           done_fire;

    // Latched input word
    logic [1:0]                  op_reg;
    logic                        gate_reg;
    logic                        run_reg;
    logic                        open_reg;
    logic [gpe_pkg::CUR_W-1:0]   cur_reg;

    // Datapath registers
    logic [gpe_pkg::SEG_W-1:0]   seg_reg;
    logic [gpe_pkg::CUR_W-1:0]   curc_reg;
    logic [gpe_pkg::NUM_W-1:0]   num_reg;
    logic [gpe_pkg::PROD_W-1:0]  prod_reg;
    logic [gpe_pkg::NUM_W-1:0]   q0_reg;
    logic [gpe_pkg::NUM_W-1:0]   rem_reg;
    logic [gpe_pkg::STEP_W-1:0]  step_reg;

    // Gate state
    logic [PB-1:0]               pos_reg  [2];
    logic [gpe_pkg::DIST_W-1:0]  dist_reg [2];
    logic                        fast_reg [2];

    // Limit registers
    logic signed [gpe_pkg::LIMIT_W-1:0] upper_reg;
    logic signed [gpe_pkg::LIMIT_W-1:0] lower_reg;
    logic signed [gpe_pkg::LIMIT_W-1:0] fopen_reg;
    logic signed [gpe_pkg::LIMIT_W-1:0] fclose_reg;

    // Output register
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic signed [gpe_pkg::OUT_POS_W-1:0] out_pos_reg;
    logic [gpe_pkg::DIST_W-1:0]           out_dist_reg;
    logic [gpe_pkg::STEP_W-1:0]           out_step_reg;
    logic                                 out_fast_reg;

    // Combinational datapath
    logic [gpe_pkg::CUR_W-1:0]    curc;
    logic [gpe_pkg::SEG_W-1:0]    seg;
    logic [gpe_pkg::DX_W-1:0]     div_d;
    logic [gpe_pkg::RECIP_W-1:0]  recip;
    logic [gpe_pkg::NUM_W-1:0]    q0;
    logic [gpe_pkg::NUM_W-1:0]    q_fix;
    logic [PB-1:0]                pos_sel;
    logic signed [EW-1:0]         pos_s;
    logic signed [EW-1:0]         p1_s;
    logic [PB-1:0]                p1;
    logic [PB-1:0]                p2;
    logic                         fast_f;

    // Handshake
    assign item_in.ready = !busy;
    assign accept        = item_in.valid && item_in.ready;
    assign stall         = out_valid_reg && !result_out.ready;
    assign done_fire     = busy && ctrl.done && !stall;

    assign cond.upd   = (op_reg == gpe_pkg::OP_UPDATE) && run_reg;
    assign cond.stop  = (op_reg == gpe_pkg::OP_STOP);
    assign cond.start = (op_reg == gpe_pkg::OP_START);

    gpe_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .cond  (cond),
        .stall (stall),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    // Clamp current to the table span and find its segment
    always_comb
    begin
        if (cur_reg < gpe_pkg::CUR_PTS[0])
            curc = gpe_pkg::CUR_PTS[0];
        else if (cur_reg > gpe_pkg::CUR_PTS[gpe_pkg::TABLE_POINTS-1])
            curc = gpe_pkg::CUR_PTS[gpe_pkg::TABLE_POINTS-1];
        else
            curc = cur_reg;
        seg = '0;
        for (int j = 1; j < gpe_pkg::TABLE_POINTS; j++)
        begin
            if (curc >= gpe_pkg::CUR_PTS[j])
                seg = gpe_pkg::SEG_W'(j);
        end
    end

    // Divisor and its reciprocal: segment width or the speed divisor
    always_comb
    begin
        unique case (ctrl.dsel)
            gpe_pkg::D_SEG:
            begin
                div_d = gpe_pkg::SEG_DX[seg_reg];
                recip = gpe_pkg::SEG_RECIP[seg_reg];
            end
            gpe_pkg::D_SPEED:
            begin
                div_d = gpe_pkg::DX_W'(gpe_pkg::SPEED_DIVISOR);
                recip = gpe_pkg::RECIP_SPEED;
            end
            default:
            begin
                div_d = gpe_pkg::SEG_DX[seg_reg];
                recip = gpe_pkg::SEG_RECIP[seg_reg];
            end
        endcase
    end

    // Estimated quotient, and its one-step correction from the held remainder
    assign q0    = gpe_pkg::NUM_W'(prod_reg >> gpe_pkg::RECIP_SHIFT);
    assign q_fix = q0_reg + gpe_pkg::NUM_W'(rem_reg >= gpe_pkg::NUM_W'(div_d));

    // Stop clamp: upper limit first, then lower on the wrapped value; also the start check's fast-ride flag
    always_comb
    begin
        pos_sel = pos_reg[gate_reg];
        pos_s   = EW'(signed'(pos_sel));
        if (pos_s > EW'(upper_reg))
            p1 = PB'(upper_reg);
        else
            p1 = pos_sel;
        p1_s = EW'(signed'(p1));
        if (p1_s < EW'(lower_reg))
            p2 = PB'(lower_reg);
        else
            p2 = p1;
        if (open_reg)
            fast_f = (pos_s < EW'(fopen_reg));
        else
            fast_f = (pos_s > EW'(fclose_reg));
    end

    // Latch the input word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= item_in.opcode;
            gate_reg <= item_in.gate_select;
            run_reg  <= item_in.motor_running;
            open_reg <= item_in.direction_open;
            cur_reg  <= item_in.motor_current;
        end
    end

    // Datapath steps driven by the control word
    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            unique case (ctrl.uop)
                gpe_pkg::U_SEG:
                begin
                    seg_reg  <= seg;
                    curc_reg <= curc;
                end
                gpe_pkg::U_MUL:
                    num_reg <= gpe_pkg::NUM_W'(gpe_pkg::SEG_DY[seg_reg] *
                               (curc_reg - gpe_pkg::CUR_PTS[seg_reg]));
                gpe_pkg::U_RECIP:
                    prod_reg <= gpe_pkg::PROD_W'(num_reg) * gpe_pkg::PROD_W'(recip);
                gpe_pkg::U_REM:
                begin
                    q0_reg  <= q0;
                    rem_reg <= num_reg - gpe_pkg::NUM_W'(q0 * div_d);
                end
                gpe_pkg::U_QUOT:
                    num_reg <= gpe_pkg::NUM_W'(gpe_pkg::SPD_PTS[seg_reg]) - q_fix;
                default:
                begin
                end
            endcase
        end
    end

    // Gate state and step register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < 2; g++)
            begin
                pos_reg[g]  <= '0;
                dist_reg[g] <= '0;
                fast_reg[g] <= 1'b0;
            end
            step_reg <= '0;
        end
        else if (accept)
            step_reg <= '0;
        else if (busy)
        begin
            unique case (ctrl.uop)
                gpe_pkg::U_STEP:
                begin
                    step_reg           <= gpe_pkg::STEP_W'(q_fix);
                    dist_reg[gate_reg] <= dist_reg[gate_reg]
                                          + gpe_pkg::DIST_W'(gpe_pkg::STEP_W'(q_fix));
                    if (open_reg)
                        pos_reg[gate_reg] <= pos_sel + PB'(gpe_pkg::STEP_W'(q_fix));
                    else
                        pos_reg[gate_reg] <= pos_sel - PB'(gpe_pkg::STEP_W'(q_fix));
                end
                gpe_pkg::U_STOP:
                    pos_reg[gate_reg] <= p2;
                gpe_pkg::U_START:
                    fast_reg[gate_reg] <= fast_f;
                default:
                begin
                end
            endcase
        end
    end

    // Limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg  <= gpe_pkg::RST_POS_UPPER;
            lower_reg  <= gpe_pkg::RST_POS_LOWER;
            fopen_reg  <= gpe_pkg::RST_FAST_OPEN;
            fclose_reg <= gpe_pkg::RST_FAST_CLOSE;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                gpe_pkg::REG_POS_UPPER:  upper_reg  <= cfg_data;
                gpe_pkg::REG_POS_LOWER:  lower_reg  <= cfg_data;
                gpe_pkg::REG_FAST_OPEN:  fopen_reg  <= cfg_data;
                gpe_pkg::REG_FAST_CLOSE: fclose_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Output register: load on the last step, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (done_fire)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            out_pos_reg  <= gpe_pkg::OUT_POS_W'(EW'(pos_sel));
            out_dist_reg <= dist_reg[gate_reg];
            out_step_reg <= step_reg;
            out_fast_reg <= fast_reg[gate_reg];
        end
    end

    assign result_out.valid              = out_valid_reg;
    assign result_out.position           = out_pos_reg;
    assign result_out.travelled_distance = out_dist_reg;
    assign result_out.step_distance      = out_step_reg;
    assign result_out.fast_ride_allowed  = out_fast_reg;

`ifndef SYNTHESIS
    // An accepted word keeps the sequencer busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("sequencer not busy after accepted word");

    // A result appears only after a finishing step that was not stalled
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(done_fire))
        else $error("result word without a finished item");

    // A nonzero step is reported only for a running update
    a_step_update: assert property (@(posedge clk) disable iff (!rst_n)
        (done_fire && step_reg != '0) |-> cond.upd)
        else $error("step reported for a word that is not a running update");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the gate position estimator: predicted gate state against result words.
module testbench;

    // Opcode that the block leaves without effect
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int IDLE_LIMIT     = 4000;
    localparam int TAIL_CYCLES    = 20;
    localparam int LONG_HOLD      = 150;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_WORDS    = 270;

    // Current-to-speed knots, current in table units
    localparam int unsigned CURRENT_KNOTS [8] = '{8, 11, 15, 20, 25, 30, 40, 50};
    localparam int unsigned SPEED_KNOTS   [8] = '{587, 575, 561, 544, 529, 515, 490, 380};
    localparam int unsigned PERIOD_DIVISOR    = 20;

    typedef struct packed {
        logic [1:0]                opcode;
        logic                      gate;
        logic                      running;
        logic                      toward_open;
        logic [gpe_pkg::CUR_W-1:0] current;
    } gate_word_t;

    typedef struct packed {
        logic signed [gpe_pkg::OUT_POS_W-1:0] position;
        logic [gpe_pkg::DIST_W-1:0]           distance;
        logic [gpe_pkg::STEP_W-1:0]           step;
        logic                                 fast;
    } gate_state_t;

    // Dead-reckoning model of both gates and the queue of states still owed
    class gate_position_tracker;
        logic signed [15:0] gate_pos [2];
        logic [15:0]        gate_dist [2];
        logic               gate_fast [2];
        logic signed [15:0] limit_reg [4];
        gate_state_t        predicted_states [$];
        int                 mismatch_count;

        function new();
            for (int g = 0; g < 2; g++)
            begin
                gate_pos[g]  = '0;
                gate_dist[g] = '0;
                gate_fast[g] = 1'b0;
            end
            limit_reg[gpe_pkg::REG_POS_UPPER]  = 16'sd10000;
            limit_reg[gpe_pkg::REG_POS_LOWER]  = 16'sd0;
            limit_reg[gpe_pkg::REG_FAST_OPEN]  = 16'sd2000;
            limit_reg[gpe_pkg::REG_FAST_CLOSE] = 16'sd8000;
            mismatch_count = 0;
        endfunction

        function void load_reg(logic [1:0] idx, logic [15:0] value);
            limit_reg[idx] = value;
        endfunction

        // Clamp current to the table span and interpolate, truncating
        function int unsigned speed_for(logic [gpe_pkg::CUR_W-1:0] current);
            int unsigned c;
            int unsigned k;
            int unsigned x1;
            int unsigned y1;
            int unsigned y2;
            c = 32'(current);
            if (c > CURRENT_KNOTS[7])
                c = CURRENT_KNOTS[7];
            if (c < CURRENT_KNOTS[0])
                c = CURRENT_KNOTS[0];
            k = 0;
            while (k < 8 && c >= CURRENT_KNOTS[k])
                k++;
            if (k >= 8)
                return SPEED_KNOTS[7];
            x1 = CURRENT_KNOTS[k-1];
            y1 = SPEED_KNOTS[k-1];
            y2 = SPEED_KNOTS[k];
            return y1 - (y1 - y2) * (c - x1) / (CURRENT_KNOTS[k] - x1);
        endfunction

        // Advance the selected gate by one accepted word and queue its state
        function void note_word(gate_word_t w);
            int                 g;
            logic [4:0]         step;
            logic signed [15:0] p;
            g    = int'(w.gate);
            step = '0;
            p    = gate_pos[g];
            case (w.opcode)
                gpe_pkg::OP_UPDATE:
                begin
                    if (w.running)
                    begin
                        step = 5'(speed_for(w.current) / PERIOD_DIVISOR);
                        gate_dist[g] = gate_dist[g] + 16'(step);
                        if (w.toward_open)
                            gate_pos[g] = gate_pos[g] + 16'(step);
                        else
                            gate_pos[g] = gate_pos[g] - 16'(step);
                    end
                end
                gpe_pkg::OP_STOP:
                begin
                    // Upper first, so a lower limit above the upper wins
                    if (p > limit_reg[gpe_pkg::REG_POS_UPPER])
                        p = limit_reg[gpe_pkg::REG_POS_UPPER];
                    if (p < limit_reg[gpe_pkg::REG_POS_LOWER])
                        p = limit_reg[gpe_pkg::REG_POS_LOWER];
                    gate_pos[g] = p;
                end
                gpe_pkg::OP_START:
                begin
                    if (w.toward_open)
                        gate_fast[g] = (p < limit_reg[gpe_pkg::REG_FAST_OPEN]);
                    else
                        gate_fast[g] = (p > limit_reg[gpe_pkg::REG_FAST_CLOSE]);
                end
                default: ;
            endcase
            predicted_states.push_back('{gate_pos[g], gate_dist[g], step, gate_fast[g]});
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
            mismatch_count++;
        endtask

        // Compare one result word with the oldest predicted state
        task check_word(gate_state_t got);
            gate_state_t want;
            if (predicted_states.size() == 0)
            begin
                report_mismatch("unexpected word, position", int'(got.position), 0);
                return;
            end
            want = predicted_states.pop_front();
            if (got.position !== want.position)
                report_mismatch("position", int'(got.position), int'(want.position));
            if (got.distance !== want.distance)
                report_mismatch("travelled_distance", int'(got.distance),
                                int'(want.distance));
            if (got.step !== want.step)
                report_mismatch("step_distance", int'(got.step), int'(want.step));
            if (got.fast !== want.fast)
                report_mismatch("fast_ride_allowed", int'(got.fast), int'(want.fast));
        endtask
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wen;
    logic [1:0]                   cfg_index;
    logic [gpe_pkg::LIMIT_W-1:0]  cfg_data;

    gpe_item_if   item_bus ();
    gpe_result_if result_bus ();

    gate_position_tracker tracker;

    bit tx_idle;
    bit rx_idle;
    int hold_off_cycles;
    int idle_count;

    gate_position_estimator_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_bus),
        .result_out (result_bus),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // End the run when no word moves on either channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= IDLE_LIMIT)
            begin
                $display("gate_position_estimator_unit regression: fail");
                $finish;
            end
        end
    end

    function automatic gate_word_t make_word(logic [1:0] op, bit g, bit run, bit toward_open,
                                             int unsigned current);
        gate_word_t w;
        w.opcode      = op;
        w.gate        = g;
        w.running     = run;
        w.toward_open = toward_open;
        w.current     = gpe_pkg::CUR_W'(current);
        return w;
    endfunction

    // Offer one word after a drawn gap and hold it until accepted
    task automatic send_word(gate_word_t w);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            item_bus.valid = 1'b0;
        end
        @(negedge clk);
        item_bus.opcode         = w.opcode;
        item_bus.gate_select    = w.gate;
        item_bus.motor_running  = w.running;
        item_bus.direction_open = w.toward_open;
        item_bus.motor_current  = w.current;
        item_bus.valid          = 1'b1;
        do
            @(posedge clk);
        while (!item_bus.ready);
        tracker.note_word(w);
    endtask

    task automatic send_random(int count);
        gate_word_t  w;
        int unsigned r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            w.opcode      = (r < 58) ? gpe_pkg::OP_UPDATE : (r < 74) ? gpe_pkg::OP_STOP :
                            (r < 93) ? gpe_pkg::OP_START : OP_UNUSED;
            w.gate        = 1'($urandom_range(0, 1));
            w.running     = ($urandom_range(0, 99) < 85);
            w.toward_open = 1'($urandom_range(0, 1));
            w.current     = $urandom_range(0, 1) ? gpe_pkg::CUR_W'($urandom_range(0, 60))
                                                 : gpe_pkg::CUR_W'($urandom_range(0, 1023));
            send_word(w);
        end
    endtask

    // Drop valid and wait until every predicted state has been returned
    task automatic drain();
        @(negedge clk);
        item_bus.valid = 1'b0;
        while (tracker.predicted_states.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_wen = 1'b0;
        tracker.load_reg(idx, value);
    endtask

    task automatic set_limits(logic [15:0] upper, logic [15:0] lower,
                              logic [15:0] fast_open, logic [15:0] fast_close);
        drain();
        write_reg(gpe_pkg::REG_POS_UPPER, upper);
        write_reg(gpe_pkg::REG_POS_LOWER, lower);
        write_reg(gpe_pkg::REG_FAST_OPEN, fast_open);
        write_reg(gpe_pkg::REG_FAST_CLOSE, fast_close);
    endtask

    function automatic logic [15:0] pick_limit();
        if ($urandom_range(0, 2) == 0)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 800) - 400);
    endfunction

    // Accept result words after drawn stalls, with one long hold on request
    task automatic receive_words();
        int          stall;
        gate_state_t got;
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                @(negedge clk);
                result_bus.ready = 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            stall = rx_idle ? $urandom_range(0, 7) : 0;
            repeat (stall)
            begin
                @(negedge clk);
                result_bus.ready = 1'b0;
            end
            @(negedge clk);
            result_bus.ready = 1'b1;
            do
                @(posedge clk);
            while (!result_bus.valid);
            got.position = result_bus.position;
            got.distance = result_bus.travelled_distance;
            got.step     = result_bus.step_distance;
            got.fast     = result_bus.fast_ride_allowed;
            tracker.check_word(got);
        end
    endtask

    initial
    begin
        int unsigned knot_currents [17] = '{0, 7, 8, 9, 11, 14, 15, 20, 24, 25, 30, 39, 40,
                                            49, 50, 51, 1023};
        tracker = new();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        hold_off_cycles = 0;
        idle_count = 0;
        rst_n     = 1'b0;
        cfg_wen   = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        item_bus.valid          = 1'b0;
        item_bus.opcode         = gpe_pkg::OP_UPDATE;
        item_bus.gate_select    = 1'b0;
        item_bus.motor_running  = 1'b0;
        item_bus.direction_open = 1'b0;
        item_bus.motor_current  = '0;
        result_bus.ready        = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        fork
            receive_words();
        join_none

        // Directed: start checks, every table segment, the clamps at reset limits, an idle update and an unused opcode
        send_word(make_word(gpe_pkg::OP_START, 1'b0, 1'b0, 1'b1, 0));
        send_word(make_word(gpe_pkg::OP_START, 1'b1, 1'b1, 1'b0, 1023));
        for (int i = 0; i < 17; i++)
            send_word(make_word(gpe_pkg::OP_UPDATE, 1'(i % 2), 1'b1, (i % 2) == 0,
                                knot_currents[i]));
        send_word(make_word(gpe_pkg::OP_UPDATE, 1'b1, 1'b0, 1'b1, 1023));
        send_word(make_word(gpe_pkg::OP_STOP, 1'b1, 1'b1, 1'b1, 1023));
        send_word(make_word(gpe_pkg::OP_STOP, 1'b0, 1'b0, 1'b0, 0));
        send_word(make_word(OP_UNUSED, 1'b1, 1'b1, 1'b1, 1023));
        send_word(make_word(gpe_pkg::OP_START, 1'b0, 1'b0, 1'b0, 0));

        // Push both gates to the edge of the position range and wrap them
        set_limits(16'sd32767, 16'sd32760, 16'sd2000, 16'sd8000);
        send_word(make_word(gpe_pkg::OP_STOP, 1'b0, 1'b0, 1'b1, 0));
        send_word(make_word(gpe_pkg::OP_UPDATE, 1'b0, 1'b1, 1'b1, 8));
        send_word(make_word(gpe_pkg::OP_START, 1'b0, 1'b0, 1'b1, 0));
        set_limits(-16'sd32760, -16'sd32768, 16'sd2000, 16'sd8000);
        send_word(make_word(gpe_pkg::OP_STOP, 1'b1, 1'b0, 1'b0, 0));
        send_word(make_word(gpe_pkg::OP_UPDATE, 1'b1, 1'b1, 1'b0, 1023));
        send_word(make_word(gpe_pkg::OP_START, 1'b1, 1'b0, 1'b0, 0));

        // Hold the receiver off while words keep coming back to back
        set_limits(16'sd300, -16'sd300, 16'sd100, -16'sd100);
        tx_idle = 1'b0;
        hold_off_cycles = LONG_HOLD;
        send_random(24);

        // Random phases: near limits, extremes, crossed limits, then drawn settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: set_limits(16'sd300, -16'sd300, 16'sd100, -16'sd100);
                1: set_limits(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
                2: set_limits(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
                default: set_limits(pick_limit(), pick_limit(), pick_limit(), pick_limit());
            endcase
            tx_idle = (ph != 1) && (ph != 3);
            rx_idle = (ph != 1) && (ph != 2);
            send_random(PHASE_WORDS);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.mismatch_count == 0)
            $display("gate_position_estimator_unit regression: pass");
        else
            $display("gate_position_estimator_unit regression: fail");
        $finish;
    end

endmodule
